>>> design/ais_pkg.sv
package ais_pkg;

  localparam int WORD_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [WORD_W-1:0] word_t;

  // value handed from one cell to the next during insertion
  typedef struct packed {
    logic  valid;
    word_t value;
  } carry_t;

  // contents of one cell as seen by its neighbor
  typedef struct packed {
    logic  full;
    word_t value;
  } slot_t;

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

endpackage

>>> design/ais_if.sv
interface ais_in_if import ais_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t value;
  logic  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface ais_out_if import ais_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t sorted_value;
  logic  last_result;

  modport source (output valid, output sorted_value, output last_result, input ready);
  modport sink (input valid, input sorted_value, input last_result, output ready);
endinterface

>>> design/ascending_integer_sorter.sv
// ascending integer sorter: systolic insertion chain of MAX_ITEMS cells
//
// items (sink): one signed 32-bit value per transaction, last_item closes
// the set. the transaction that brings the set to MAX_ITEMS also closes it.
// results (source): the set in ascending signed order, one value per
// transaction, last_result set on the final one.
//
// loading takes one item per cycle; every cell keeps the smaller of its
// value and the incoming one and hands the larger to its neighbor
// through its carry register. after the closing item the chain settles
// until a value displaced along the longest path has come to rest, then
// drains by shifting toward cell 0, one result per cycle while the output
// register is not held by a low results.ready.
// items.ready is low from the closing transaction until the chain is empty.
// the output register holds its result while results.ready is low; the
// drain shift pauses with it, so no result is lost.
// synchronous reset empties every cell and drops any pending result.
module ascending_integer_sorter import ais_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ais_in_if.sink    items,
  ais_out_if.source results
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int TMR_W = $clog2(MAX_ITEMS);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SETTLE = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic [TMR_W-1:0] timer;

  logic  out_valid;
  word_t out_value;
  logic  out_last;

  carry_t     carries [MAX_ITEMS+1];
  slot_t      slots   [MAX_ITEMS+1];
  cell_ctrl_t ctrl;

  logic accept;
  logic closing;
  logic advance;

  assign items.ready = (state == ST_LOAD);
  assign accept      = items.valid && items.ready;
  // set closes on the last mark or when the chain is full
  assign closing     = items.last_item || (count == CNT_W'(MAX_ITEMS - 1));
  assign advance     = !out_valid || results.ready;
  assign ctrl.shift  = (state == ST_DRAIN) && advance && slots[0].full;

  // new value enters at cell 0
  assign carries[0] = '{valid: accept, value: items.value};
  // nothing beyond the last cell
  assign slots[MAX_ITEMS] = '{full: 1'b0, value: '0};

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    ais_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .carry_in  (carries[i]),
      .right     (slots[i+1]),
      .carry_out (carries[i+1]),
      .slot      (slots[i])
    );
  end

  // control: load, settle, drain
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      timer <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (closing) begin
              count <= '0;
              timer <= '0;
              state <= ST_SETTLE;
            end else begin
              count <= count + CNT_W'(1);
            end
          end
        end
        ST_SETTLE: begin
          // wait until every displaced value has come to rest
          if (timer == TMR_W'(MAX_ITEMS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            timer <= timer + TMR_W'(1);
          end
        end
        ST_DRAIN: begin
          if (advance && !slots[0].full) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // output register, loaded from cell 0 as the chain shifts
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctrl.shift;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      out_value <= slots[0].value;
      out_last  <= !slots[1].full;
    end
  end

  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.last_result  = out_last;

endmodule

>>> design/ais_cell.sv
module ais_cell import ais_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  carry_t     carry_in,
  input  slot_t      right,
  output carry_t     carry_out,
  output slot_t      slot
);

  logic  full;
  word_t value;
  carry_t carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      full        <= 1'b0;
      carry.valid <= 1'b0;
    end else if (ctrl.shift) begin
      // drain: take the neighbor's contents
      full        <= right.full;
      value       <= right.value;
      carry.valid <= 1'b0;
    end else begin
      carry.valid <= 1'b0;
      if (carry_in.valid) begin
        if (!full) begin
          full  <= 1'b1;
          value <= carry_in.value;
        end else if (carry_in.value < value) begin
          // keep the smaller one, pass the displaced value on
          value       <= carry_in.value;
          carry.value <= value;
          carry.valid <= 1'b1;
        end else begin
          carry.value <= carry_in.value;
          carry.valid <= 1'b1;
        end
      end
    end
  end

  assign carry_out = carry;
  assign slot      = '{full: full, value: value};

endmodule

>>> bench/testbench.sv
module testbench import ais_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // sizes of the run
  localparam int SET_DEPTH     = MAX_ITEMS_DEF;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 335;
  // receiver hold-off: starts once this many results have gone by
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;
  // drain wait covers loading, settling and draining a full set, plus slack
  localparam int DRAIN_CYCLES  = 3 * SET_DEPTH + 16;
  // longest correct quiet stretch is the hold-off plus settling, taken several times
  localparam int IDLE_LIMIT    = 4000;
  localparam int PRINT_CAP     = 40;

  localparam word_t W_MAX = word_t'(32'h7fff_ffff);
  localparam word_t W_MIN = word_t'(32'h8000_0000);

  // one load transaction; known marks a row whose result is typed in below
  typedef struct packed {
    word_t value;
    logic  last;
    logic  known;
    word_t known_value;
  } load_item_t;

  // one expected sorted result
  typedef struct packed {
    word_t value;
    logic  last;
  } sorted_entry_t;

  logic clk;
  logic rst;

  ais_in_if  items_ch ();
  ais_out_if results_ch ();

  ascending_integer_sorter #(
    .MAX_ITEMS(SET_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  // directed rows: single-element runs at the extremes and around zero come first, their
  // result is the value itself with the last mark; the rest is predicted
  load_item_t directed_rows [DIRECTED_ROWS] = '{
    '{W_MAX, 1'b1, 1'b1, W_MAX},
    '{W_MIN, 1'b1, 1'b1, W_MIN},
    '{word_t'(0), 1'b1, 1'b1, word_t'(0)},
    '{word_t'(-1), 1'b1, 1'b1, word_t'(-1)},
    // extremes mixed in one set
    '{W_MAX, 1'b0, 1'b0, word_t'(0)},
    '{W_MIN, 1'b0, 1'b0, word_t'(0)},
    '{word_t'(0), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(-1), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(1), 1'b0, 1'b0, word_t'(0)},
    '{W_MIN + 1, 1'b1, 1'b0, word_t'(0)},
    // equal values
    '{word_t'(7), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(7), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(-7), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(7), 1'b1, 1'b0, word_t'(0)},
    // arriving in descending order
    '{word_t'(40), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(30), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(20), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(10), 1'b1, 1'b0, word_t'(0)},
    // already ascending
    '{word_t'(-3), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(-2), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(-1), 1'b1, 1'b0, word_t'(0)},
    // two minimums
    '{W_MIN, 1'b0, 1'b0, word_t'(0)},
    '{W_MIN, 1'b1, 1'b0, word_t'(0)},
    // alternating bit patterns
    '{word_t'(32'h5555_5555), 1'b0, 1'b0, word_t'(0)},
    '{word_t'(32'haaaa_aaaa), 1'b1, 1'b0, word_t'(0)}
  };

  load_item_t    load_plan [$];
  word_t         pending_set [$];
  sorted_entry_t sorted_expect_q [$];

  int mismatches   = 0;
  int loaded_count = 0;
  int results_seen = 0;
  bit feed_done    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one line per mismatch, printing capped so a broken block does not flood the log
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, wanted);
    mismatches++;
  endtask

  // collect a loaded value; when the set closes, queue its ascending order
  task automatic collect_and_sort(input load_item_t it);
    word_t ordered [$];
    word_t key;
    int    j;
    pending_set.push_back(it.value);
    // the set closes on the last mark or when the store is full
    if (!it.last && pending_set.size() < SET_DEPTH)
      return;
    if (it.known) begin
      sorted_expect_q.push_back('{value: it.known_value, last: 1'b1});
      pending_set.delete();
      return;
    end
    ordered = pending_set;
    // insertion sort on signed words
    for (int i = 1; i < ordered.size(); i++) begin
      key = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = key;
    end
    for (int k = 0; k < ordered.size(); k++)
      sorted_expect_q.push_back('{value: ordered[k], last: (k == ordered.size() - 1)});
    pending_set.delete();
  endtask

  // both monitors sample at the edge, so they see the values of the transaction
  always @(posedge clk) begin : monitor
    sorted_entry_t want;
    if (!rst) begin
      if (items_ch.valid && items_ch.ready) begin
        collect_and_sort(load_plan[loaded_count]);
        loaded_count++;
      end
      if (results_ch.valid && results_ch.ready) begin
        results_seen++;
        if (sorted_expect_q.size() == 0) begin
          report_mismatch("result with nothing pending", results_ch.sorted_value, 'x);
        end else begin
          want = sorted_expect_q.pop_front();
          if (results_ch.sorted_value !== want.value)
            report_mismatch("sorted_value", results_ch.sorted_value, want.value);
          if (results_ch.last_result !== want.last)
            report_mismatch("last_result", 32'(results_ch.last_result), 32'(want.last));
        end
      end
    end
  end

  // sender: bursts of random length, random gaps, valid held until accepted
  initial begin : feeder
    int idx;
    int burst_left;
    int gap_left;
    items_ch.valid     <= 1'b0;
    items_ch.value     <= '0;
    items_ch.last_item <= 1'b0;
    idx        = 0;
    burst_left = $urandom_range(1, 24);
    gap_left   = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (idx < load_plan.size()) begin
      if (items_ch.valid && items_ch.ready) begin
        idx++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // most bursts run back to back, some leave a gap
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        end
      end else if (!items_ch.valid && gap_left > 0) begin
        gap_left--;
      end
      if (idx < load_plan.size() && gap_left == 0) begin
        items_ch.valid     <= 1'b1;
        items_ch.value     <= load_plan[idx].value;
        items_ch.last_item <= load_plan[idx].last;
      end else begin
        items_ch.valid <= 1'b0;
      end
      @(posedge clk);
    end
    feed_done = 1'b1;
  end

  // receiver: ready pattern changes mode at random intervals; one long
  // hold-off lets the chain fill and the input stall behind it
  initial begin : drain_side
    int mode;
    int mode_left;
    int hold_left;
    bit held;
    results_ch.ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: results_ch.ready <= 1'b1;
          1: results_ch.ready <= 1'($urandom_range(0, 1));
          2: results_ch.ready <= ($urandom_range(0, 3) == 0);
          default: results_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // watchdog: any cycle without a transaction on either side counts
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main
    int    run_len;
    int    kind;
    int    vmode;
    bit    no_mark;
    bit    first_run;
    word_t v;

    // directed table first
    for (int r = 0; r < DIRECTED_ROWS; r++)
      load_plan.push_back(directed_rows[r]);

    // random runs; the first one fills the store with no last mark
    first_run = 1'b1;
    while (load_plan.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
      kind = first_run ? 0 : $urandom_range(0, 99);
      no_mark = 1'b0;
      if (kind < 8) begin
        // full store, closed by the fill itself or by a mark on the same item
        run_len = SET_DEPTH;
        no_mark = first_run ? 1'b1 : 1'($urandom_range(0, 1));
      end else if (kind < 25) begin
        run_len = $urandom_range(9, SET_DEPTH - 1);
      end else begin
        run_len = $urandom_range(1, 8);
      end
      vmode = $urandom_range(0, 3);
      for (int k = 0; k < run_len; k++) begin
        case (vmode)
          0: v = $urandom;
          // narrow range, lots of equal values
          1: v = word_t'($urandom_range(0, 6)) - 3;
          2: begin
            case ($urandom_range(0, 4))
              0: v = W_MAX;
              1: v = W_MIN;
              2: v = word_t'(0);
              3: v = word_t'(-1);
              default: v = word_t'(1);
            endcase
          end
          default: v = $urandom_range(0, 1) ? word_t'($urandom) : word_t'($urandom_range(0, 6)) - 3;
        endcase
        load_plan.push_back('{value: v, last: (k == run_len - 1) && !no_mark,
                              known: 1'b0, known_value: word_t'(0)});
      end
      first_run = 1'b0;
    end

    // reset held, then released at an edge
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every item accepted and every result seen, then watch for strays
    while (!(feed_done && sorted_expect_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && sorted_expect_q.size() == 0 && pending_set.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
design/ais_pkg.sv
design/ais_if.sv
design/ais_cell.sv
design/ascending_integer_sorter.sv
bench/testbench.sv
